/* sv/rtpl16_pkg.sv */
// ----------------------------------------------------------------------------
// rtpl16_pkg
// Shared types and constants for the RTP L16 stereo packetiser.
// ----------------------------------------------------------------------------
package rtpl16_pkg;

	localparam int MAX_FRAMES = 1152;
	localparam int FRAME_CNT_W = 11;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int PT_W = 7;
	localparam int SSRC_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID = 1'b1;
	localparam logic [PT_W-1:0] PT_RESET = 7'd10;

	localparam int SAMPLE_W = 18;
	localparam logic [7:0] HDR_FIRST_BYTE = 8'h80;

	// byte position within a frame's output: header 0..11, payload 12..15
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 4'd12;
	localparam logic [POS_W-1:0] POS_LAST = 4'd15;

	typedef struct packed {
		logic        hdr;
		logic        last;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [15:0] left;
		logic [15:0] right;
	} cmd_t;

endpackage

/* sv/rtp_l16_packetizer.sv */
// ----------------------------------------------------------------------------
// rtp_l16_packetizer
// RTP version 2 packetiser for L16 stereo audio, one byte per output beat.
// ----------------------------------------------------------------------------
// Each accepted frame yields four payload beats (left then right, big endian),
// preceded by a 12-byte RTP header when it opens a packet. Input conversion
// and packet bookkeeping happen as a frame is accepted; a two-entry command
// queue then feeds the serialiser, so the input takes a new frame while
// earlier ones are still being sent, unless the queue is full. A frame's
// first byte passes through its queue entry and then the output register.
// payload_type and source_id are sampled as header bytes leave, so write
// them only while the block is idle.
module rtp_l16_packetizer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [rtpl16_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rtpl16_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [rtpl16_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [rtpl16_pkg::SAMPLE_W-1:0] right_sample,
	input  logic                                   end_of_packet,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [7:0]                             packet_byte,
	output logic                                   last_byte
);
	import rtpl16_pkg::*;

	logic [PT_W-1:0]   pt_q;
	logic [SSRC_W-1:0] ssrc_q;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_valid;
	cmd_t q_cmd;
	cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q   <= PT_RESET;
			ssrc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAYLOAD_TYPE: pt_q   <= cfg_data[PT_W-1:0];
				CFG_SOURCE_ID:    ssrc_q <= cfg_data[SSRC_W-1:0];
				default: ;
			endcase
		end
	end

	rtpl16_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.end_of_packet(end_of_packet),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	rtpl16_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.pop     (q_pop),
		.full    (q_full),
		.q_valid (q_valid),
		.head    (q_head)
	);

	rtpl16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (q_head),
		.q_pop      (q_pop),
		.pt         (pt_q),
		.ssrc       (ssrc_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.packet_byte(packet_byte),
		.last_byte  (last_byte)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_first_beat_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.hdr) |=> (packet_byte == HDR_FIRST_BYTE) && !last_byte)
		else $error("packet did not open with header byte");
`endif

endmodule

/* sv/rtpl16_front.sv */
// ----------------------------------------------------------------------------
// rtpl16_front
// Accepts frames, converts samples to L16 and tracks packet state.
// ----------------------------------------------------------------------------
module rtpl16_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [rtpl16_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [rtpl16_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic                                     end_of_packet,
	input  logic                                     q_full,
	output logic                                     q_push,
	output rtpl16_pkg::cmd_t                         q_cmd
);
	import rtpl16_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] Q_ONE = 18'sd65536;

	logic [FRAME_CNT_W-1:0] frames_q;
	logic [FRAME_CNT_W-1:0] frames_nxt;
	logic [31:0]            ts_q;
	logic [15:0]            seq_q;
	logic                   close;

	// clamp to +-1, scale by 32767, truncate toward zero
	function automatic logic [15:0] to_l16(input logic signed [SAMPLE_W-1:0] s);
		logic signed [SAMPLE_W-1:0] v;
		logic [SAMPLE_W-1:0]        a;
		logic [31:0]                p;
		logic [15:0]                r;
		v = s;
		if (v > Q_ONE)
			v = Q_ONE;
		if (v < -Q_ONE)
			v = -Q_ONE;
		a = v[SAMPLE_W-1] ? (-v) : v;
		p = {a[16:0], 15'b0} - {15'b0, a[16:0]};
		r = p[31:16];
		return v[SAMPLE_W-1] ? (-r) : r;
	endfunction

	assign in_ready   = !q_full;
	assign q_push     = in_valid && !q_full;
	assign frames_nxt = frames_q + FRAME_CNT_W'(1);
	assign close      = end_of_packet || (frames_nxt >= FRAME_CNT_W'(MAX_FRAMES));

	always_comb begin
		q_cmd.hdr   = (frames_q == '0);
		q_cmd.last  = close;
		q_cmd.seq   = seq_q;
		q_cmd.ts    = ts_q;
		q_cmd.left  = to_l16(left_sample);
		q_cmd.right = to_l16(right_sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			ts_q     <= '0;
			seq_q    <= '0;
		end else if (q_push) begin
			ts_q <= ts_q + 32'd1;
			if (close) begin
				frames_q <= '0;
				seq_q    <= seq_q + 16'd1;
			end else begin
				frames_q <= frames_nxt;
			end
		end
	end

endmodule

/* sv/rtpl16_queue.sv */
// ----------------------------------------------------------------------------
// rtpl16_queue
// Short command queue between the front and the byte serialiser.
// ----------------------------------------------------------------------------
module rtpl16_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtpl16_pkg::cmd_t push_cmd,
	input  logic             pop,
	output logic             full,
	output logic             q_valid,
	output rtpl16_pkg::cmd_t head
);
	import rtpl16_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ptr_inc(wr_q);
			if (pop)
				rd_q <= ptr_inc(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

/* sv/rtpl16_back.sv */
// ----------------------------------------------------------------------------
// rtpl16_back
// Byte serialiser: header and payload bytes into a registered output beat.
// ----------------------------------------------------------------------------
module rtpl16_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  rtpl16_pkg::cmd_t                head,
	output logic                            q_pop,
	input  logic [rtpl16_pkg::PT_W-1:0]     pt,
	input  logic [rtpl16_pkg::SSRC_W-1:0]   ssrc,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      packet_byte,
	output logic                            last_byte
);
	import rtpl16_pkg::*;

	cmd_t             cmd_q;
	logic             active_q;
	logic [POS_W-1:0] pos_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;

	cmd_t             src;
	logic [POS_W-1:0] spos;
	logic             adv;
	logic             have;

	function automatic logic [7:0] byte_sel(input cmd_t c, input logic [POS_W-1:0] p,
	                                        input logic [PT_W-1:0] t,
	                                        input logic [SSRC_W-1:0] s);
		logic [7:0] b;
		unique case (p)
			4'd0:  b = HDR_FIRST_BYTE;
			4'd1:  b = {1'b0, t};
			4'd2:  b = c.seq[15:8];
			4'd3:  b = c.seq[7:0];
			4'd4:  b = c.ts[31:24];
			4'd5:  b = c.ts[23:16];
			4'd6:  b = c.ts[15:8];
			4'd7:  b = c.ts[7:0];
			4'd8:  b = s[31:24];
			4'd9:  b = s[23:16];
			4'd10: b = s[15:8];
			4'd11: b = s[7:0];
			4'd12: b = c.left[15:8];
			4'd13: b = c.left[7:0];
			4'd14: b = c.right[15:8];
			4'd15: b = c.right[7:0];
		endcase
		return b;
	endfunction

	always_comb begin
		src   = active_q ? cmd_q : head;
		spos  = active_q ? pos_q : (head.hdr ? '0 : POS_PAYLOAD);
		adv   = !out_valid_q || out_ready;
		have  = active_q || q_valid;
		q_pop = adv && !active_q && q_valid;
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = byte_q;
	assign last_byte   = last_q;

	always_ff @(posedge clk) begin
		if (adv && have) begin
			byte_q <= byte_sel(src, spos, pt, ssrc);
			last_q <= (spos == POS_LAST) && src.last;
			cmd_q  <= src;
			pos_q  <= spos + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have)
				active_q <= (spos != POS_LAST);
		end
	end

endmodule

/* dv/rtp_l16_packetizer_test.sv */
// ----------------------------------------------------------------------------
// rtp_l16_packetizer_test
// Self-checking testbench for the RTP L16 stereo packetiser. A directed table
// covers reset header values, clamping and truncation toward zero. Random
// phases follow under several payload type and SSRC settings. Both channels
// idle at random. Every output beat is compared with a queue filled by an
// in-bench predictor.
// ----------------------------------------------------------------------------
module rtp_l16_packetizer_test;
	import rtpl16_pkg::*;

	localparam int Q_ONE = 65536;
	localparam int L16_SCALE = 32767;
	localparam int RUN_LIMIT = 5_000_000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] val;
		logic       fin;
	} pkt_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
		logic                       eop;
		logic                       typed;
		logic [15:0]                tl;
		logic [15:0]                tr;
	} dir_row_t;

	localparam int NDIR = 14;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       end_of_packet;
	logic                       out_valid;
	logic                       out_ready;
	logic [7:0]                 packet_byte;
	logic                       last_byte;

	// predictor state
	logic [PT_W-1:0]        pt_cfg;
	logic [SSRC_W-1:0]      ssrc_cfg;
	logic [15:0]            seq_no;
	logic [31:0]            ts_count;
	logic [FRAME_CNT_W-1:0] frames_open;

	pkt_beat_t beat_q[$];
	int        errors;
	int        cycles;
	bit        calm;

	dir_row_t dir_tab [NDIR] = '{
		'{18'sd0,       18'sd0,       1'b0, 1'b1, 16'h0000, 16'h0000},
		'{18'sd65536,  -18'sd65536,   1'b0, 1'b1, 16'h7FFF, 16'h8001},
		'{18'sd131071, -18'sd131072,  1'b0, 1'b1, 16'h7FFF, 16'h8001},
		'{18'sd65537,  -18'sd65537,   1'b0, 1'b1, 16'h7FFF, 16'h8001},
		'{18'sd65535,  -18'sd65535,   1'b0, 1'b1, 16'h7FFE, 16'h8002},
		'{18'sd1,      -18'sd1,       1'b0, 1'b1, 16'h0000, 16'h0000},
		'{18'sd3,      -18'sd3,       1'b0, 1'b1, 16'h0001, 16'hFFFF},
		'{18'sd32768,  -18'sd32768,   1'b1, 1'b1, 16'h3FFF, 16'hC001},
		'{-18'sd1,      18'sd1,       1'b1, 1'b1, 16'h0000, 16'h0000},
		'{18'sd87381,  -18'sd87381,   1'b1, 1'b0, 16'h0000, 16'h0000},
		'{18'sd12345,  -18'sd54321,   1'b0, 1'b0, 16'h0000, 16'h0000},
		'{-18'sd100000, 18'sd99999,   1'b1, 1'b0, 16'h0000, 16'h0000},
		'{18'sd65536,   18'sd65536,   1'b1, 1'b1, 16'h7FFF, 16'h7FFF},
		'{-18'sd65536, -18'sd65536,   1'b1, 1'b1, 16'h8001, 16'h8001}
	};

	rtp_l16_packetizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.end_of_packet (end_of_packet),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packet_byte   (packet_byte),
		.last_byte     (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// clamp to +-1, scale, truncate toward zero
	function automatic logic [15:0] l16_of(logic signed [SAMPLE_W-1:0] s);
		longint v;
		longint p;
		v = s;
		if (v > Q_ONE)
			v = Q_ONE;
		if (v < -Q_ONE)
			v = -Q_ONE;
		p = v * L16_SCALE;
		if (p < 0)
			p = -((-p) >>> 16);
		else
			p = p >>> 16;
		return p[15:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		int s;
		r = $urandom_range(0, 99);
		if (r < 55)
			s = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
		else if (r < 80)
			s = int'($urandom());
		else begin
			case ($urandom_range(0, 7))
				0: s = Q_ONE;
				1: s = -Q_ONE;
				2: s = Q_ONE + 1;
				3: s = -Q_ONE - 1;
				4: s = 131071;
				5: s = -131072;
				6: s = 0;
				default: s = $urandom_range(0, 1) ? 1 : -1;
			endcase
		end
		return SAMPLE_W'(s);
	endfunction

	task automatic push_beat(input logic [7:0] v, input logic f);
		pkt_beat_t b;
		b.val = v;
		b.fin = f;
		beat_q.push_back(b);
	endtask

	task automatic predict_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic eop, input logic typed,
			input logic [15:0] tl, input logic [15:0] tr);
		logic [15:0] wl;
		logic [15:0] wr;
		logic        close;
		wl = typed ? tl : l16_of(l);
		wr = typed ? tr : l16_of(r);
		if (frames_open == 0) begin
			push_beat(HDR_FIRST_BYTE, 1'b0);
			push_beat({1'b0, pt_cfg}, 1'b0);
			push_beat(seq_no[15:8], 1'b0);
			push_beat(seq_no[7:0], 1'b0);
			push_beat(ts_count[31:24], 1'b0);
			push_beat(ts_count[23:16], 1'b0);
			push_beat(ts_count[15:8], 1'b0);
			push_beat(ts_count[7:0], 1'b0);
			push_beat(ssrc_cfg[31:24], 1'b0);
			push_beat(ssrc_cfg[23:16], 1'b0);
			push_beat(ssrc_cfg[15:8], 1'b0);
			push_beat(ssrc_cfg[7:0], 1'b0);
		end
		ts_count = ts_count + 32'd1;
		frames_open = frames_open + FRAME_CNT_W'(1);
		close = eop || (frames_open >= MAX_FRAMES);
		push_beat(wl[15:8], 1'b0);
		push_beat(wl[7:0], 1'b0);
		push_beat(wr[15:8], 1'b0);
		push_beat(wr[7:0], close);
		if (close) begin
			seq_no = seq_no + 16'd1;
			frames_open = '0;
		end
	endtask

	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic eop, input logic typed,
			input logic [15:0] tl, input logic [15:0] tr);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		end_of_packet <= eop;
		do
			@(posedge clk);
		while (!in_ready);
		predict_frame(l, r, eop, typed, tl, tr);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (beat_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAYLOAD_TYPE)
			pt_cfg = d[PT_W-1:0];
		else if (idx == CFG_SOURCE_ID)
			ssrc_cfg = d[SSRC_W-1:0];
		@(posedge clk);
	endtask

	// packets of random length; the phase ends on a closed packet
	task automatic run_random(input int n);
		int plen;
		int k;
		int sent;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				plen = 1;
			else if (r < 80)
				plen = $urandom_range(1, 8);
			else
				plen = $urandom_range(9, 40);
			for (k = 0; k < plen && sent < n; k++) begin
				send_frame(rand_sample(), rand_sample(),
					(k == plen - 1) || (sent == n - 1), 1'b0, 16'h0, 16'h0);
				sent++;
			end
		end
	endtask

	// output side: random stalls, beat check
	initial begin
		int stall;
		pkt_beat_t want;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (beat_q.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected beat %h last %b", $realtime, packet_byte,
							last_byte);
					errors++;
				end else begin
					want = beat_q.pop_front();
					if (packet_byte !== want.val || last_byte !== want.fin) begin
						if (errors < MAX_REPORTS)
							$display("%0t: beat mismatch, expected %h last %b, got %h last %b",
								$realtime, want.val, want.fin, packet_byte, last_byte);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = gap_len();
				out_ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		wait (cycles >= RUN_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int i;
		int ph;
		cycles = 0;
		errors = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PAYLOAD_TYPE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		left_sample <= '0;
		right_sample <= '0;
		end_of_packet <= 1'b0;
		pt_cfg = PT_RESET;
		ssrc_cfg = '0;
		seq_no = '0;
		ts_count = '0;
		frames_open = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < NDIR; i++)
			send_frame(dir_tab[i].l, dir_tab[i].r, dir_tab[i].eop, dir_tab[i].typed,
				dir_tab[i].tl, dir_tab[i].tr);
		settle();

		// upper bits beyond payload_type must be dropped
		write_reg(CFG_PAYLOAD_TYPE, 32'hFFFF_FFFF);
		write_reg(CFG_SOURCE_ID, 32'hFFFF_FFFF);
		run_random(80);
		settle();

		write_reg(CFG_PAYLOAD_TYPE, 32'hFFFF_FF80);
		write_reg(CFG_SOURCE_ID, 32'h0000_0000);
		run_random(80);
		settle();

		for (ph = 0; ph < 3; ph++) begin
			write_reg(CFG_PAYLOAD_TYPE, $urandom());
			write_reg(CFG_SOURCE_ID, $urandom());
			calm = (ph == 1);
			run_random(80);
			settle();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (beat_q.size() != 0) begin
			$display("%0d beats never arrived", beat_q.size());
			errors++;
		end
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
sv/rtpl16_pkg.sv
sv/rtpl16_front.sv
sv/rtpl16_queue.sv
sv/rtpl16_back.sv
sv/rtp_l16_packetizer.sv
dv/rtp_l16_packetizer_test.sv
